// ----- design/falling_sand_grid_step_assert.svh -----
// Assertion macros used by the falling-sand grid checker.
`ifndef FALLING_SAND_GRID_STEP_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSGS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("falling sand grid: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FSGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("falling sand grid: assertion failed");

`endif

// ----- design/fsgs_pkg.sv -----
// Types, constants and control structs of the falling-sand grid block.
package fsgs_pkg;

    localparam int CFG_W = 32;
    localparam int PCT_W = 7;
    localparam int ROW_W = 7;
    localparam int COL_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [CFG_W-1:0] SEED_RST = 32'd1;
    localparam logic [PCT_W-1:0] SPAWN_PCT_RST = 7'd10;
    localparam logic [PCT_W-1:0] MOVE_PCT_RST = 7'd95;

    // Reciprocal of 100 for an exact 32-bit quotient.
    localparam logic [CFG_W-1:0] RECIP_MUL = 32'h51EB_851F;
    localparam int RECIP_SHIFT = 37;
    localparam logic [PCT_W-1:0] DRAW_MOD = 7'd100;

    localparam int SPAWN_SRCS = 4;
    localparam int SPAWN_ROUNDS = 2;
    localparam int SPAWN_HALF = 10;
    localparam int SPAWN_SPAN = 2 * SPAWN_HALF + 1;

    localparam int NB_COUNT = 5;
    localparam int NB_DX [NB_COUNT] = '{0, 1, -1, -1, 1};
    localparam int NB_DY [NB_COUNT] = '{1, 1, 1, 0, 0};

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WALL  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CELL_EMPTY = 2'd0,
        CELL_SAND  = 2'd1,
        CELL_WALL  = 2'd2
    } cell_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RNG_SEED  = 2'd0,
        CFG_SPAWN_PCT = 2'd1,
        CFG_MOVE_PCT  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ASEL_ITEM  = 4'd0,
        ASEL_CUR   = 4'd1,
        ASEL_NB    = 4'd2,
        ASEL_PUSH  = 4'd3,
        ASEL_SPAWN = 4'd4,
        ASEL_CLR   = 4'd5,
        ASEL_TOP   = 4'd6,
        ASEL_BOT   = 4'd7,
        ASEL_LEFT  = 4'd8,
        ASEL_RIGHT = 4'd9
    } addr_sel_t;

    typedef struct packed {
        kind_t            kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             wall_present;
    } req_t;

    typedef struct packed {
        cell_t cell_type;
        logic  done_res;
    } rsp_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        cell_t     wr_cell;
        logic      item_load;
        logic      clr_inc;
        logic      par_clear;
        logic      par_toggle;
        logic      rng_step;
        logic      rng_mul;
        logic      spawn_init;
        logic      spawn_inc;
        logic      sweep_init;
        logic      sweep_next;
        logic      nb_init;
        logic      nb_inc;
        logic      push_init;
        logic      push_dec;
        logic      brd_row_init;
        logic      brd_col_init;
        logic      brd_inc_c;
        logic      brd_inc_r;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  wall;
        logic  in_grid;
        logic  row_zero;
        cell_t rd_cell;
        logic  clr_last;
        logic  spawn_last;
        logic  sweep_last;
        logic  nb_ok;
        logic  nb_last;
        logic  push_top;
        logic  c_last;
        logic  r_last;
        logic  lt_spawn;
        logic  lt_move;
        logic  out_busy;
    } dp_status_t;

endpackage

// ----- design/fsgs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fsgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fsgs_ctrl.sv -----
// Sequencer of the falling-sand grid: drives the datapath one step per state.
module fsgs_ctrl
    import fsgs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [26:0] {
        ST_IDLE     = 27'h0000001,
        ST_INIT     = 27'h0000002,
        ST_CLR      = 27'h0000004,
        ST_DISP     = 27'h0000008,
        ST_FIN_RD   = 27'h0000010,
        ST_FIN_WAIT = 27'h0000020,
        ST_SP_STEP  = 27'h0000040,
        ST_SP_MUL   = 27'h0000080,
        ST_SP_DEC   = 27'h0000100,
        ST_SW_INIT  = 27'h0000200,
        ST_SW_RD    = 27'h0000400,
        ST_SW_CHK   = 27'h0000800,
        ST_SW_ADV   = 27'h0001000,
        ST_MV_STEP  = 27'h0002000,
        ST_MV_MUL   = 27'h0004000,
        ST_MV_DEC   = 27'h0008000,
        ST_NB_RD    = 27'h0010000,
        ST_NB_CHK   = 27'h0020000,
        ST_MV_CLR   = 27'h0040000,
        ST_BR_TOP   = 27'h0080000,
        ST_BR_BOT   = 27'h0100000,
        ST_BR_LEFT  = 27'h0200000,
        ST_BR_RIGHT = 27'h0400000,
        ST_W_WAIT   = 27'h0800000,
        ST_P_RD     = 27'h1000000,
        ST_P_CHK    = 27'h2000000,
        ST_P_WALL   = 27'h4000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_INIT, ST_CLR:
            begin
                cmd.addr_sel = ASEL_CLR;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_EMPTY;
                cmd.clr_inc = 1'b1;
                if (status.clr_last)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FIN_RD;
                end
            end
            ST_DISP:
            begin
                unique case (status.kind)
                    KIND_TICK:
                    begin
                        cmd.spawn_init = 1'b1;
                        cmd.par_toggle = 1'b1;
                        state_next = ST_SP_STEP;
                    end
                    KIND_WALL:
                    begin
                        if (status.in_grid)
                        begin
                            cmd.addr_sel = ASEL_ITEM;
                            cmd.mem_rd = 1'b1;
                            state_next = ST_W_WAIT;
                        end
                        else
                        begin
                            state_next = ST_FIN_RD;
                        end
                    end
                    KIND_READ:
                    begin
                        state_next = ST_FIN_RD;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.par_clear = 1'b1;
                        state_next = ST_CLR;
                    end
                    default:
                    begin
                        state_next = ST_FIN_RD;
                    end
                endcase
            end
            ST_FIN_RD:
            begin
                cmd.addr_sel = ASEL_ITEM;
                cmd.mem_rd = 1'b1;
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SP_STEP:
            begin
                cmd.rng_step = 1'b1;
                state_next = ST_SP_MUL;
            end
            ST_SP_MUL:
            begin
                cmd.rng_mul = 1'b1;
                state_next = ST_SP_DEC;
            end
            ST_SP_DEC:
            begin
                cmd.addr_sel = ASEL_SPAWN;
                cmd.wr_cell = CELL_SAND;
                cmd.mem_wr = status.lt_spawn;
                cmd.spawn_inc = 1'b1;
                state_next = status.spawn_last ? ST_SW_INIT : ST_SP_STEP;
            end
            ST_SW_INIT:
            begin
                cmd.sweep_init = 1'b1;
                state_next = ST_SW_RD;
            end
            ST_SW_RD:
            begin
                cmd.addr_sel = ASEL_CUR;
                cmd.mem_rd = 1'b1;
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                state_next = (status.rd_cell == CELL_SAND) ? ST_MV_STEP : ST_SW_ADV;
            end
            ST_SW_ADV:
            begin
                if (status.sweep_last)
                begin
                    cmd.brd_row_init = 1'b1;
                    state_next = ST_BR_TOP;
                end
                else
                begin
                    cmd.sweep_next = 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_MV_STEP:
            begin
                cmd.rng_step = 1'b1;
                state_next = ST_MV_MUL;
            end
            ST_MV_MUL:
            begin
                cmd.rng_mul = 1'b1;
                state_next = ST_MV_DEC;
            end
            ST_MV_DEC:
            begin
                if (status.lt_move)
                begin
                    cmd.nb_init = 1'b1;
                    state_next = ST_NB_RD;
                end
                else
                begin
                    state_next = ST_SW_ADV;
                end
            end
            ST_NB_RD:
            begin
                if (status.nb_ok)
                begin
                    cmd.addr_sel = ASEL_NB;
                    cmd.mem_rd = 1'b1;
                    state_next = ST_NB_CHK;
                end
                else if (status.nb_last)
                begin
                    state_next = ST_SW_ADV;
                end
                else
                begin
                    cmd.nb_inc = 1'b1;
                end
            end
            ST_NB_CHK:
            begin
                if (status.rd_cell == CELL_EMPTY)
                begin
                    cmd.addr_sel = ASEL_NB;
                    cmd.mem_wr = 1'b1;
                    cmd.wr_cell = CELL_SAND;
                    state_next = ST_MV_CLR;
                end
                else if (status.nb_last)
                begin
                    state_next = ST_SW_ADV;
                end
                else
                begin
                    cmd.nb_inc = 1'b1;
                    state_next = ST_NB_RD;
                end
            end
            ST_MV_CLR:
            begin
                cmd.addr_sel = ASEL_CUR;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_EMPTY;
                state_next = ST_SW_ADV;
            end
            ST_BR_TOP:
            begin
                cmd.addr_sel = ASEL_TOP;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_EMPTY;
                state_next = ST_BR_BOT;
            end
            ST_BR_BOT:
            begin
                cmd.addr_sel = ASEL_BOT;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_EMPTY;
                if (status.c_last)
                begin
                    cmd.brd_col_init = 1'b1;
                    state_next = ST_BR_LEFT;
                end
                else
                begin
                    cmd.brd_inc_c = 1'b1;
                    state_next = ST_BR_TOP;
                end
            end
            ST_BR_LEFT:
            begin
                cmd.addr_sel = ASEL_LEFT;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_WALL;
                state_next = ST_BR_RIGHT;
            end
            ST_BR_RIGHT:
            begin
                cmd.addr_sel = ASEL_RIGHT;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_WALL;
                if (status.r_last)
                begin
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    cmd.brd_inc_r = 1'b1;
                    state_next = ST_BR_LEFT;
                end
            end
            ST_W_WAIT:
            begin
                cmd.addr_sel = ASEL_ITEM;
                state_next = ST_FIN_RD;
                if (status.rd_cell == CELL_WALL && !status.wall)
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_cell = CELL_EMPTY;
                end
                else if (status.rd_cell == CELL_EMPTY && status.wall)
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_cell = CELL_WALL;
                end
                else if (status.rd_cell == CELL_SAND && status.wall)
                begin
                    if (status.row_zero)
                    begin
                        state_next = ST_P_WALL;
                    end
                    else
                    begin
                        cmd.push_init = 1'b1;
                        state_next = ST_P_RD;
                    end
                end
            end
            ST_P_RD:
            begin
                cmd.addr_sel = ASEL_PUSH;
                cmd.mem_rd = 1'b1;
                state_next = ST_P_CHK;
            end
            ST_P_CHK:
            begin
                if (status.rd_cell == CELL_EMPTY)
                begin
                    cmd.addr_sel = ASEL_PUSH;
                    cmd.mem_wr = 1'b1;
                    cmd.wr_cell = CELL_SAND;
                    state_next = ST_P_WALL;
                end
                else if (status.push_top)
                begin
                    state_next = ST_P_WALL;
                end
                else
                begin
                    cmd.push_dec = 1'b1;
                    state_next = ST_P_RD;
                end
            end
            ST_P_WALL:
            begin
                cmd.addr_sel = ASEL_ITEM;
                cmd.mem_wr = 1'b1;
                cmd.wr_cell = CELL_WALL;
                state_next = ST_FIN_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/fsgs_datapath.sv -----
// Datapath of the falling-sand grid: grid memory, cursors, random draws and result register.
module fsgs_datapath
    import fsgs_pkg::*;
#(
    parameter int GRID_W = 128,
    parameter int GRID_H = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp
);

    localparam int RW = $clog2(GRID_H);
    localparam int CW = $clog2(GRID_W);
    localparam int AW = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int SPK = GRID_W / SPAWN_SRCS;
    localparam int SPAWN_BASE = SPK / 2 - SPAWN_HALF;

    req_t             item_reg;
    logic [RW-1:0]    cur_r_reg, cur_r_next;
    logic [CW-1:0]    cur_c_reg, cur_c_next;
    logic [RW-1:0]    push_r_reg, push_r_next;
    logic [2:0]       nb_reg, nb_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [1:0]       sp_src_reg, sp_src_next;
    logic             sp_rnd_reg, sp_rnd_next;
    logic [4:0]       sp_j_reg, sp_j_next;
    logic             par_reg, par_next;
    logic [CFG_W-1:0] lfsr_reg, lfsr_next;
    logic [6:0]       q_reg;
    logic [PCT_W-1:0] spawn_pct_reg, spawn_pct_next;
    logic [PCT_W-1:0] move_pct_reg, move_pct_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg;

    logic [RW-1:0]    item_r;
    logic [CW-1:0]    item_c;
    logic [RW-1:0]    nb_r;
    logic [CW-1:0]    nb_c;
    logic [CW-1:0]    spawn_c;
    logic [CW-1:0]    sw_start, sw_end;
    logic [AW-1:0]    addr;
    logic [1:0]       rd_data;
    logic [2*CFG_W-1:0] prod;
    logic [13:0]      q100;
    logic [6:0]       draw;
    logic             in_grid;
    logic [CFG_W-1:0] lfsr_step;

    assign item_r = RW'(item_reg.row);
    assign item_c = CW'(item_reg.col);
    assign in_grid = (int'(item_reg.row) < GRID_H) && (int'(item_reg.col) < GRID_W);
    assign nb_r = cur_r_reg + RW'(NB_DY[nb_reg]);
    assign nb_c = CW'(int'(cur_c_reg) + NB_DX[nb_reg]);
    assign spawn_c = CW'(SPAWN_BASE + SPK * int'(sp_src_reg) + int'(sp_j_reg));
    assign sw_start = par_reg ? CW'(1) : CW'(GRID_W - 1);
    assign sw_end = par_reg ? CW'(GRID_W - 2) : CW'(1);

    assign lfsr_step = {1'b0, lfsr_reg[CFG_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign prod = lfsr_reg * RECIP_MUL;
    assign q100 = q_reg * DRAW_MOD;
    assign draw = lfsr_reg[6:0] - q100[6:0];

    always_comb
    begin
        case (cmd.addr_sel)
            ASEL_ITEM:  addr = {item_r, item_c};
            ASEL_CUR:   addr = {cur_r_reg, cur_c_reg};
            ASEL_NB:    addr = {nb_r, nb_c};
            ASEL_PUSH:  addr = {push_r_reg, item_c};
            ASEL_SPAWN: addr = {RW'(0), spawn_c};
            ASEL_CLR:   addr = clr_cnt_reg;
            ASEL_TOP:   addr = {RW'(0), cur_c_reg};
            ASEL_BOT:   addr = {RW'(GRID_H - 1), cur_c_reg};
            ASEL_LEFT:  addr = {cur_r_reg, CW'(0)};
            ASEL_RIGHT: addr = {cur_r_reg, CW'(GRID_W - 1)};
            default:    addr = {item_r, item_c};
        endcase
    end

    fsgs_ram #(
        .WIDTH(2),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.mem_wr),
        .waddr (addr),
        .wdata (cmd.wr_cell),
        .re    (cmd.mem_rd),
        .raddr (addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        cur_r_next = cur_r_reg;
        cur_c_next = cur_c_reg;
        push_r_next = push_r_reg;
        nb_next = nb_reg;
        clr_cnt_next = clr_cnt_reg;
        sp_src_next = sp_src_reg;
        sp_rnd_next = sp_rnd_reg;
        sp_j_next = sp_j_reg;
        par_next = par_reg;
        lfsr_next = lfsr_reg;
        spawn_pct_next = spawn_pct_reg;
        move_pct_next = move_pct_reg;
        out_valid_next = out_valid_reg;

        if (cmd.clr_inc)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.par_clear)
        begin
            par_next = 1'b0;
        end
        else if (cmd.par_toggle)
        begin
            par_next = ~par_reg;
        end

        if (cmd.spawn_init)
        begin
            sp_src_next = '0;
            sp_rnd_next = 1'b0;
            sp_j_next = '0;
        end
        else if (cmd.spawn_inc)
        begin
            if (int'(sp_j_reg) == SPAWN_SPAN - 1)
            begin
                sp_j_next = '0;
                sp_rnd_next = ~sp_rnd_reg;
                if (sp_rnd_reg)
                begin
                    sp_src_next = sp_src_reg + 1'b1;
                end
            end
            else
            begin
                sp_j_next = sp_j_reg + 1'b1;
            end
        end

        if (cmd.sweep_init)
        begin
            cur_r_next = RW'(GRID_H - 1);
            cur_c_next = sw_start;
        end
        else if (cmd.sweep_next)
        begin
            if (cur_c_reg == sw_end)
            begin
                cur_r_next = cur_r_reg - 1'b1;
                cur_c_next = sw_start;
            end
            else if (par_reg)
            begin
                cur_c_next = cur_c_reg + 1'b1;
            end
            else
            begin
                cur_c_next = cur_c_reg - 1'b1;
            end
        end
        else if (cmd.brd_row_init)
        begin
            cur_c_next = CW'(1);
        end
        else if (cmd.brd_inc_c)
        begin
            cur_c_next = cur_c_reg + 1'b1;
        end
        else if (cmd.brd_col_init)
        begin
            cur_r_next = RW'(1);
        end
        else if (cmd.brd_inc_r)
        begin
            cur_r_next = cur_r_reg + 1'b1;
        end

        if (cmd.nb_init)
        begin
            nb_next = '0;
        end
        else if (cmd.nb_inc)
        begin
            nb_next = nb_reg + 1'b1;
        end

        if (cmd.push_init)
        begin
            push_r_next = item_r - 1'b1;
        end
        else if (cmd.push_dec)
        begin
            push_r_next = push_r_reg - 1'b1;
        end

        if (cmd.rng_step)
        begin
            lfsr_next = lfsr_step;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RNG_SEED:  lfsr_next = cfg_data;
                CFG_SPAWN_PCT: spawn_pct_next = cfg_data[PCT_W-1:0];
                CFG_MOVE_PCT:  move_pct_next = cfg_data[PCT_W-1:0];
                default:       lfsr_next = lfsr_reg;
            endcase
        end

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_r_reg <= '0;
            cur_c_reg <= '0;
            push_r_reg <= '0;
            nb_reg <= '0;
            clr_cnt_reg <= '0;
            sp_src_reg <= '0;
            sp_rnd_reg <= 1'b0;
            sp_j_reg <= '0;
            par_reg <= 1'b0;
            lfsr_reg <= SEED_RST;
            spawn_pct_reg <= SPAWN_PCT_RST;
            move_pct_reg <= MOVE_PCT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_r_reg <= cur_r_next;
            cur_c_reg <= cur_c_next;
            push_r_reg <= push_r_next;
            nb_reg <= nb_next;
            clr_cnt_reg <= clr_cnt_next;
            sp_src_reg <= sp_src_next;
            sp_rnd_reg <= sp_rnd_next;
            sp_j_reg <= sp_j_next;
            par_reg <= par_next;
            lfsr_reg <= lfsr_next;
            spawn_pct_reg <= spawn_pct_next;
            move_pct_reg <= move_pct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= req;
        end
        if (cmd.rng_mul)
        begin
            q_reg <= prod[RECIP_SHIFT+6:RECIP_SHIFT];
        end
        if (cmd.out_load)
        begin
            out_reg.cell_type <= in_grid ? cell_t'(rd_data) : CELL_EMPTY;
            out_reg.done_res <= 1'b1;
        end
    end

    always_comb
    begin
        status.kind = item_reg.kind;
        status.wall = item_reg.wall_present;
        status.in_grid = in_grid;
        status.row_zero = (item_reg.row == '0);
        status.rd_cell = cell_t'(rd_data);
        status.clr_last = (clr_cnt_reg == '1);
        status.spawn_last = (int'(sp_src_reg) == SPAWN_SRCS - 1)
            && (int'(sp_rnd_reg) == SPAWN_ROUNDS - 1)
            && (int'(sp_j_reg) == SPAWN_SPAN - 1);
        status.sweep_last = (cur_r_reg == '0) && (cur_c_reg == sw_end);
        status.nb_ok = !((NB_DY[nb_reg] != 0) && (int'(cur_r_reg) == GRID_H - 1))
            && !((NB_DX[nb_reg] > 0) && (int'(cur_c_reg) == GRID_W - 1));
        status.nb_last = (int'(nb_reg) == NB_COUNT - 1);
        status.push_top = (push_r_reg == '0);
        status.c_last = (int'(cur_c_reg) == GRID_W - 2);
        status.r_last = (int'(cur_r_reg) == GRID_H - 2);
        status.lt_spawn = (draw < spawn_pct_reg);
        status.lt_move = (draw < move_pct_reg);
        status.out_busy = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

// ----- design/falling_sand_grid_step.sv -----
// Falling-sand grid top level: request and response channels plus configuration port.
// The grid of GRID_H by GRID_W two-bit cells lives in one RAM with a registered read port,
// so every cell visit goes through a read state and a decision state. After reset the block
// stalls requests for a clearing pass over all 2^(clog2(GRID_H) + clog2(GRID_W)) addresses
// (16384 at the default size); a clear request runs the same sweep. A wall request that
// places a wall on sand scans upward cell by cell to push it. A tick request makes its 168
// spawn draws, reads every swept cell, draws for each sand cell, probes its neighbors for a
// move, then makes 2*(GRID_W-2) + 2*(GRID_H-2) border writes. One request is worked on at a
// time; the next one is taken while a response still waits in the output register.
module falling_sand_grid_step
    import fsgs_pkg::*;
#(
    parameter int GRID_W = 128,
    parameter int GRID_H = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fsgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fsgs_datapath #(
        .GRID_W(GRID_W),
        .GRID_H(GRID_H)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- design/fsgs_checker.sv -----
// Port-level checker of the falling-sand grid and its bind to the top level.
`include "falling_sand_grid_step_assert.svh"

module fsgs_checker
    import fsgs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    logic req_take;
    logic rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // The block works on one request at a time.
    `FSGS_ASSERT_NEXT(a_busy_after_take, req_take, req_stall)
    // No response can be ready in the cycle right after a request is taken.
    `FSGS_ASSERT_NEXT(a_no_instant_rsp, req_take, !$rose(rsp_valid))
    // A taken response is never followed directly by another one.
    `FSGS_ASSERT_NEXT(a_single_rsp, rsp_take, !rsp_valid)
    `FSGS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `FSGS_ASSERT_NOW(a_rsp_done, rsp_valid, rsp.done_res)

endmodule

bind falling_sand_grid_step fsgs_checker u_fsgs_checker (.*);
